// ===== rtl/core/pfp_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the plane-from-three-points pipeline.
// No dependencies.
package pfp_pkg;
  localparam int COORD_BITS_DEF       = 24;
  localparam int NORMAL_FRAC_BITS_DEF = 30;
  localparam int SCALE_BITS           = 31;
  localparam int SUM_BITS             = 2 * SCALE_BITS + 2;
  localparam int ROOT_BITS            = SUM_BITS / 2;
endpackage

// ===== rtl/core/pfp_in_if.sv =====
`timescale 1ns / 1ps
// Input item channel: three points, valid/ready handshake.
// No dependencies.
interface pfp_in_if #(
  parameter int CB = 24
);
  logic valid;
  logic ready;
  logic signed [CB-1:0] p1_x, p1_y, p1_z;
  logic signed [CB-1:0] p2_x, p2_y, p2_z;
  logic signed [CB-1:0] p3_x, p3_y, p3_z;

  modport source (
    output valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
    input  ready
  );
  modport sink (
    input  valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
    output ready
  );
endinterface

// ===== rtl/core/pfp_out_if.sv =====
`timescale 1ns / 1ps
// Result item channel: unit normal, offset, degenerate flag.
// No dependencies.
interface pfp_out_if #(
  parameter int CB = 24,
  parameter int F  = 30
);
  logic valid;
  logic ready;
  logic signed [F+1:0] normal_x, normal_y, normal_z;
  logic signed [CB:0]  offset;
  logic                degenerate;

  modport source (
    output valid, normal_x, normal_y, normal_z, offset, degenerate,
    input  ready
  );
  modport sink (
    input  valid, normal_x, normal_y, normal_z, offset, degenerate,
    output ready
  );
endinterface

// ===== rtl/core/plane_from_three_points.sv =====
`timescale 1ns / 1ps
// Plane through three points: top level with output stages.
// Depends on pfp_pkg, pfp_in_if, pfp_out_if, pfp_cross, pfp_sqrt, pfp_div.
//
// Usage:
//   in_ch carries one item: three points in signed Q(COORD_BITS-8).8.
//   out_ch carries one result per item: the unit normal in
//   Q1.NORMAL_FRAC_BITS, the offset d in Q.8 (saturated) and a degenerate
//   flag; collinear points give degenerate = 1 and all other fields 0.
//   Both channels use valid/ready; an item moves when both are high.
//   Throughput is one item per cycle while out_ch does not stall. The
//   pipeline has 8 front stages, one stage per root bit of the 32-bit
//   square root, one prep stage plus one stage per quotient bit of the
//   divider, and 5 output stages.
//   The pipeline advances as a whole while the output register is empty
//   or being taken; when out_ch stalls with a result held, every stage
//   holds and in_ch.ready drops, so nothing is lost or repeated.
//   Synchronous active-low reset clears all valid bits; nothing needs
//   clearing in the data path.
module plane_from_three_points #(
  parameter int COORD_BITS       = pfp_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = pfp_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pfp_in_if.sink    in_ch,
  pfp_out_if.source out_ch
);
  import pfp_pkg::*;

  localparam int CB      = COORD_BITS;
  localparam int F       = NORMAL_FRAC_BITS;
  localparam int QB      = F + 2;
  localparam int PRW     = F + 2 + CB;
  localparam int SW      = PRW + 2;
  localparam int QW      = SW + 1 - F;
  localparam int SQ_SIDE = 4 + 3 * CB + 3 * SCALE_BITS;
  localparam int DV_SIDE = 4 + 3 * CB;

  localparam logic [QB-1:0]        ONE     = QB'(1) << F;
  localparam logic signed [QB-1:0] N_ONE   = ONE;
  localparam logic [SW:0]          HALF    = (SW + 1)'(1) << (F - 1);
  localparam logic [QW-1:0]        LIM_POS = QW'((64'd1 << CB) - 64'd1);
  localparam logic [QW-1:0]        LIM_NEG = QW'(64'd1 << CB);

  logic en;

  logic signed [CB-1:0] pa [3];
  logic signed [CB-1:0] pb [3];
  logic signed [CB-1:0] pc [3];

  logic                  cr_valid;
  logic signed [CB-1:0]  cr_p1 [3];
  logic [2:0]            cr_neg;
  logic                  cr_degen;
  logic [SCALE_BITS-1:0] cr_sc [3];
  logic [SUM_BITS-1:0]   cr_sum;

  logic                  sq_valid;
  logic [ROOT_BITS-1:0]  sq_root;
  logic [SQ_SIDE-1:0]    sq_side_i, sq_side_o;
  logic [2:0]            sq_neg;
  logic                  sq_degen;
  logic signed [CB-1:0]  sq_p1 [3];
  logic [SCALE_BITS-1:0] sq_sc [3];

  logic                  dv_valid;
  logic [QB-1:0]         dv_q [3];
  logic [DV_SIDE-1:0]    dv_side_i, dv_side_o;
  logic [2:0]            dv_neg;
  logic                  dv_degen;
  logic signed [CB-1:0]  dv_p1 [3];

  logic [3:0]            v_r;
  logic                  out_v_r;
  logic signed [QB-1:0]  na_r [3];
  logic signed [QB-1:0]  nb_r [3];
  logic signed [QB-1:0]  nc_r [3];
  logic signed [QB-1:0]  nd_r [3];
  logic signed [CB-1:0]  pa_r [3];
  logic signed [PRW-1:0] pr_r [3];
  logic signed [SW-1:0]  s_r;
  logic [SW-1:0]         ms_r;
  logic                  sgn_r;
  logic [3:0]            dg_r;

  logic [QB-1:0]         qc [3];
  logic [SW:0]           rnd;
  logic [QW-1:0]         qo;
  logic signed [CB:0]    d_nxt;

  logic signed [QB-1:0]  nx_r, ny_r, nz_r;
  logic signed [CB:0]    off_r;
  logic                  deg_r;

  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  assign pa[0] = in_ch.p1_x;
  assign pa[1] = in_ch.p1_y;
  assign pa[2] = in_ch.p1_z;
  assign pb[0] = in_ch.p2_x;
  assign pb[1] = in_ch.p2_y;
  assign pb[2] = in_ch.p2_z;
  assign pc[0] = in_ch.p3_x;
  assign pc[1] = in_ch.p3_y;
  assign pc[2] = in_ch.p3_z;

  pfp_cross #(.CB(CB)) u_cross (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .pa       (pa),
    .pb       (pb),
    .pc       (pc),
    .valid_o  (cr_valid),
    .p1_o     (cr_p1),
    .neg_o    (cr_neg),
    .degen_o  (cr_degen),
    .sc_o     (cr_sc),
    .sum_o    (cr_sum)
  );

  assign sq_side_i = {cr_neg, cr_degen, cr_p1[2], cr_p1[1], cr_p1[0],
                      cr_sc[2], cr_sc[1], cr_sc[0]};

  pfp_sqrt #(.SIDE_W(SQ_SIDE)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (cr_valid),
    .x        (cr_sum),
    .side_i   (sq_side_i),
    .valid_o  (sq_valid),
    .root_o   (sq_root),
    .side_o   (sq_side_o)
  );

  assign {sq_neg, sq_degen, sq_p1[2], sq_p1[1], sq_p1[0],
          sq_sc[2], sq_sc[1], sq_sc[0]} = sq_side_o;

  assign dv_side_i = {sq_neg, sq_degen, sq_p1[2], sq_p1[1], sq_p1[0]};

  pfp_div #(.F(F), .SIDE_W(DV_SIDE)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (sq_valid),
    .r        (sq_root),
    .sc       (sq_sc),
    .side_i   (dv_side_i),
    .valid_o  (dv_valid),
    .q_o      (dv_q),
    .side_o   (dv_side_o)
  );

  assign {dv_neg, dv_degen, dv_p1[2], dv_p1[1], dv_p1[0]} = dv_side_o;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (dv_q[i] > ONE) ? ONE : dv_q[i];
    end
    rnd = {1'b0, ms_r} + HALF;
    qo  = rnd[SW:F];
    if (sgn_r) begin
      d_nxt = (qo > LIM_POS) ? {1'b0, {CB{1'b1}}} : qo[CB:0];
    end else begin
      d_nxt = (qo > LIM_NEG) ? {1'b1, {CB{1'b0}}} : -qo[CB:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v_r     <= {v_r[2:0], dv_valid};
      out_v_r <= v_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        na_r[i] <= dv_neg[i] ? -qc[i] : qc[i];
        pa_r[i] <= dv_p1[i];
        pr_r[i] <= na_r[i] * pa_r[i];
        nb_r[i] <= na_r[i];
        nc_r[i] <= nb_r[i];
        nd_r[i] <= nc_r[i];
      end
      dg_r  <= {dg_r[2:0], dv_degen};
      s_r   <= SW'(pr_r[0]) + SW'(pr_r[1]) + SW'(pr_r[2]);
      sgn_r <= s_r[SW-1];
      ms_r  <= s_r[SW-1] ? (~$unsigned(s_r) + 1'b1) : $unsigned(s_r);
      deg_r <= dg_r[3];
      nx_r  <= dg_r[3] ? '0 : nd_r[0];
      ny_r  <= dg_r[3] ? '0 : nd_r[1];
      nz_r  <= dg_r[3] ? '0 : nd_r[2];
      off_r <= dg_r[3] ? '0 : d_nxt;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.normal_x   = nx_r;
  assign out_ch.normal_y   = ny_r;
  assign out_ch.normal_z   = nz_r;
  assign out_ch.offset     = off_r;
  assign out_ch.degenerate = deg_r;

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.degenerate |->
      out_ch.normal_x == '0 && out_ch.normal_y == '0 &&
      out_ch.normal_z == '0 && out_ch.offset == '0)
    else $error("degenerate result with nonzero fields");

  a_normal_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.degenerate |->
      out_ch.normal_x != '0 || out_ch.normal_y != '0 || out_ch.normal_z != '0)
    else $error("zero normal on a proper plane");

  a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |->
      out_ch.normal_x <= N_ONE && out_ch.normal_x >= -N_ONE &&
      out_ch.normal_y <= N_ONE && out_ch.normal_y >= -N_ONE &&
      out_ch.normal_z <= N_ONE && out_ch.normal_z >= -N_ONE)
    else $error("normal component beyond one");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r) && $stable(dg_r))
    else $error("pipeline moved while stalled");
endmodule

// ===== rtl/core/pfp_cross.sv =====
`timescale 1ns / 1ps
// Front pipeline: edges, cross product, magnitude, normalize, squared length.
// Depends on pfp_pkg.
module pfp_cross #(
  parameter int CB = pfp_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [CB-1:0]               pa [3],
  input  logic signed [CB-1:0]               pb [3],
  input  logic signed [CB-1:0]               pc [3],
  output logic                               valid_o,
  output logic signed [CB-1:0]               p1_o [3],
  output logic [2:0]                         neg_o,
  output logic                               degen_o,
  output logic [pfp_pkg::SCALE_BITS-1:0]     sc_o [3],
  output logic [pfp_pkg::SUM_BITS-1:0]       sum_o
);
  import pfp_pkg::*;

  localparam int EW  = CB + 1;
  localparam int PW  = 2 * EW;
  localparam int CW  = PW + 1;
  localparam int LW  = $clog2(CW + 1);
  localparam int NS  = 8;
  localparam int QW2 = 2 * SCALE_BITS;

  logic [NS-1:0]           v_r;
  logic signed [CB-1:0]    p1_r [NS][3];
  logic signed [EW-1:0]    e1_r [3];
  logic signed [EW-1:0]    e2_r [3];
  logic signed [PW-1:0]    m_r [6];
  logic signed [CW-1:0]    c_r [3];
  logic [CW-1:0]           mag_r [3];
  logic [CW-1:0]           mag5_r [3];
  logic [2:0]              neg4_r, neg5_r, neg6_r, neg7_r, neg8_r;
  logic [LW-1:0]           len_r;
  logic                    degen6_r, degen7_r, degen8_r;
  logic [SCALE_BITS-1:0]   sc6_r [3];
  logic [SCALE_BITS-1:0]   sc7_r [3];
  logic [SCALE_BITS-1:0]   sc8_r [3];
  logic [QW2-1:0]          sq7_r [3];
  logic [SUM_BITS-1:0]     sum_r;

  logic [CW-1:0]            orv;
  logic [LW-1:0]            len_nxt;
  logic [CW+SCALE_BITS-1:0] ext [3];
  logic [SCALE_BITS-1:0]    sc_nxt [3];

  always_comb begin
    orv     = mag_r[0] | mag_r[1] | mag_r[2];
    len_nxt = '0;
    for (int k = 0; k < CW; k++) begin
      if (orv[k]) len_nxt = LW'(k + 1);
    end
    for (int i = 0; i < 3; i++) begin
      ext[i]    = {mag5_r[i], {SCALE_BITS{1'b0}}} >> len_r;
      sc_nxt[i] = ext[i][SCALE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1_r[0][i] <= pa[i];
        e1_r[i]    <= {pb[i][CB-1], pb[i]} - {pa[i][CB-1], pa[i]};
        e2_r[i]    <= {pc[i][CB-1], pc[i]} - {pa[i][CB-1], pa[i]};
      end
      for (int s = 1; s < NS; s++) begin
        p1_r[s] <= p1_r[s-1];
      end
      m_r[0] <= e1_r[1] * e2_r[2];
      m_r[1] <= e1_r[2] * e2_r[1];
      m_r[2] <= e1_r[2] * e2_r[0];
      m_r[3] <= e1_r[0] * e2_r[2];
      m_r[4] <= e1_r[0] * e2_r[1];
      m_r[5] <= e1_r[1] * e2_r[0];
      for (int i = 0; i < 3; i++) begin
        c_r[i]    <= {m_r[2*i][PW-1], m_r[2*i]} - {m_r[2*i+1][PW-1], m_r[2*i+1]};
        mag_r[i]  <= c_r[i][CW-1] ? (~$unsigned(c_r[i]) + 1'b1) : $unsigned(c_r[i]);
        neg4_r[i] <= c_r[i][CW-1];
        mag5_r[i] <= mag_r[i];
        sc6_r[i]  <= sc_nxt[i];
        sq7_r[i]  <= QW2'(sc6_r[i]) * QW2'(sc6_r[i]);
        sc7_r[i]  <= sc6_r[i];
        sc8_r[i]  <= sc7_r[i];
      end
      neg5_r   <= neg4_r;
      len_r    <= len_nxt;
      neg6_r   <= neg5_r;
      degen6_r <= (len_r == '0);
      neg7_r   <= neg6_r;
      degen7_r <= degen6_r;
      sum_r    <= SUM_BITS'(sq7_r[0]) + SUM_BITS'(sq7_r[1]) + SUM_BITS'(sq7_r[2]);
      neg8_r   <= neg7_r;
      degen8_r <= degen7_r;
    end
  end

  assign valid_o = v_r[NS-1];
  assign p1_o    = p1_r[NS-1];
  assign neg_o   = neg8_r;
  assign degen_o = degen8_r;
  assign sc_o    = sc8_r;
  assign sum_o   = sum_r;
endmodule

// ===== rtl/core/pfp_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage, with sideband.
// Depends on pfp_pkg.
module pfp_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [pfp_pkg::SUM_BITS-1:0]   x,
  input  logic [SIDE_W-1:0]              side_i,
  output logic                           valid_o,
  output logic [pfp_pkg::ROOT_BITS-1:0]  root_o,
  output logic [SIDE_W-1:0]              side_o
);
  import pfp_pkg::*;

  localparam int RB = ROOT_BITS;
  localparam int RW = RB + 2;

  logic [RB-1:0]       v_r;
  logic [RW-1:0]       rem_r  [RB];
  logic [RB-1:0]       root_r [RB];
  logic [SUM_BITS-1:0] x_r    [RB];
  logic [SIDE_W-1:0]   side_r [RB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[RB-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < RB; k++) begin : g_stage
    logic [RW-1:0]       rem_i;
    logic [RB-1:0]       root_i;
    logic [SUM_BITS-1:0] x_i;
    logic [SIDE_W-1:0]   sd_i;
    logic [RW-1:0]       sh;
    logic [RW-1:0]       trial;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign x_i    = x;
      assign sd_i   = side_i;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign x_i    = x_r[k-1];
      assign sd_i   = side_r[k-1];
    end

    assign sh    = {rem_i[RB-1:0], x_i[SUM_BITS-1 -: 2]};
    assign trial = {root_i, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (sh >= trial) begin
          rem_r[k]  <= sh - trial;
          root_r[k] <= {root_i[RB-2:0], 1'b1};
        end else begin
          rem_r[k]  <= sh;
          root_r[k] <= {root_i[RB-2:0], 1'b0};
        end
        x_r[k]    <= x_i << 2;
        side_r[k] <= sd_i;
      end
    end
  end

  assign valid_o = v_r[RB-1];
  assign root_o  = root_r[RB-1];
  assign side_o  = side_r[RB-1];
endmodule

// ===== rtl/core/pfp_div.sv =====
`timescale 1ns / 1ps
// Three-lane pipelined restoring divider: rounded sc * 2^F / r, sc the scaled |c|.
// Depends on pfp_pkg.
module pfp_div #(
  parameter int F      = pfp_pkg::NORMAL_FRAC_BITS_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [pfp_pkg::ROOT_BITS-1:0]   r,
  input  logic [pfp_pkg::SCALE_BITS-1:0]  sc [3],
  input  logic [SIDE_W-1:0]               side_i,
  output logic                            valid_o,
  output logic [F+1:0]                    q_o [3],
  output logic [SIDE_W-1:0]               side_o
);
  import pfp_pkg::*;

  localparam int RB = ROOT_BITS;
  localparam int QB = F + 2;
  localparam int NW = SCALE_BITS + F + 1;

  logic              vp_r;
  logic [RB-1:0]     rp_r;
  logic [NW-1:0]     np_r [3];
  logic [SIDE_W-1:0] sp_r;

  logic [QB-1:0]     v_r;
  logic [RB-1:0]     r_r    [QB];
  logic [SIDE_W-1:0] side_r [QB];
  logic [RB-1:0]     rem_r  [QB][3];
  logic [QB-1:0]     nlo_r  [QB][3];
  logic [QB-1:0]     q_r    [QB][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
      v_r  <= '0;
    end else if (en) begin
      vp_r <= in_valid;
      v_r  <= {v_r[QB-2:0], vp_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rp_r <= r;
      sp_r <= side_i;
      for (int l = 0; l < 3; l++) begin
        np_r[l] <= (NW'(sc[l]) << F) + NW'(r >> 1);
      end
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_stage
    logic [RB-1:0]     r_i;
    logic [SIDE_W-1:0] sd_i;

    if (j == 0) begin : g_first
      assign r_i  = rp_r;
      assign sd_i = sp_r;
    end else begin : g_next
      assign r_i  = r_r[j-1];
      assign sd_i = side_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[j]    <= r_i;
        side_r[j] <= sd_i;
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [RB-1:0] rem_i;
      logic [QB-1:0] nlo_i;
      logic [QB-1:0] q_i;
      logic [RB:0]   sh;
      logic [RB:0]   dif;
      logic          ge;

      if (j == 0) begin : g_first
        assign rem_i = RB'(np_r[l][NW-1:QB]);
        assign nlo_i = np_r[l][QB-1:0];
        assign q_i   = '0;
      end else begin : g_next
        assign rem_i = rem_r[j-1][l];
        assign nlo_i = nlo_r[j-1][l];
        assign q_i   = q_r[j-1][l];
      end

      assign sh  = {rem_i, nlo_i[QB-1]};
      assign ge  = (sh >= {1'b0, r_i});
      assign dif = sh - {1'b0, r_i};

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j][l] <= ge ? dif[RB-1:0] : sh[RB-1:0];
          nlo_r[j][l] <= nlo_i << 1;
          q_r[j][l]   <= {q_i[QB-2:0], ge};
        end
      end
    end
  end

  assign valid_o = v_r[QB-1];
  assign q_o     = q_r[QB-1];
  assign side_o  = side_r[QB-1];
endmodule
